>>> rtl/crs_pkg.sv
// ============================================================================
// crs_pkg: shared types and constants of the Catmull-Rom spline evaluator
// Field widths, pipeline depths, function codes and status codes.
// ============================================================================
package crs_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int CNT_W      = PT_AW + 1;
    localparam int CNT_MIN    = 4;
    localparam int FRAC_BITS  = 16;
    localparam int PARAM_W    = PT_AW + FRAC_BITS;
    localparam int COORD_W    = 32;

    localparam int FRAC_HALF  = 1 << (FRAC_BITS - 1);
    localparam int UU_W       = FRAC_BITS + 1;
    localparam int W_W        = FRAC_BITS + 6;
    localparam int PROD_W     = COORD_W + W_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int MSB_W      = $clog2(SUM_W);

    // Gradient normalization and unit scaling.
    localparam int MAG_W      = 30;
    localparam int SQ_W       = 2 * MAG_W + 2;
    localparam int ROOT_W     = MAG_W + 1;
    localparam int UNIT_SH    = 16;
    localparam int Q_W        = UNIT_SH + 1;
    localparam int NUM_W      = MAG_W + UNIT_SH + 1;

    localparam int FRONT_STAGES = 12;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int DIV_STAGES   = Q_W;
    localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STAGES + DIV_STAGES;

    // Configuration port.
    localparam int CFG_AW = 1;
    localparam int CFG_DW = CNT_W;
    localparam logic [CFG_AW-1:0] REG_LOOPED = 1'b0;
    localparam logic [CFG_AW-1:0] REG_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_POS  = 2'd1,
        FUNC_GRAD = 2'd2,
        FUNC_NONE = 2'd3
    } func_e;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Control and early result that travel beside the datapath.
    typedef struct packed {
        logic                    valid;
        logic                    pos;
        logic                    grad;
        logic                    zero;
        logic [1:0]              status;
        logic [2:0]              neg;
        logic [2:0][COORD_W-1:0] res;
    } meta_t;

endpackage

>>> rtl/crs_if.sv
// ============================================================================
// Stream interfaces of the Catmull-Rom spline evaluator
// Command channel (loads and evaluations) and result channel.
// ============================================================================
interface crs_cmd_if import crs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           func;
    logic [PT_AW-1:0]     point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [PARAM_W-1:0]   param_t;

    modport source (output valid, func, point_index, coord_x, coord_y, coord_z, param_t,
                    input ready);
    modport sink   (input valid, func, point_index, coord_x, coord_y, coord_z, param_t,
                    output ready);
endinterface

interface crs_rsp_if import crs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [COORD_W-1:0] res_x;
    logic signed [COORD_W-1:0] res_y;
    logic signed [COORD_W-1:0] res_z;
    logic [1:0]           status;

    modport source (output valid, res_x, res_y, res_z, status, input ready);
    modport sink   (input valid, res_x, res_y, res_z, status, output ready);
endinterface

>>> rtl/crs_isqrt.sv
// ============================================================================
// crs_isqrt: pipelined integer square root
// Floor square root, one result bit per register stage.
// ============================================================================
module crs_isqrt import crs_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   sq,
    output logic [ROOT_W-1:0] root
);

    logic [SQ_W-1:0] v_reg [SQRT_STAGES];
    logic [SQ_W:0]   r_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_st
        localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (2 * (SQRT_STAGES - 1 - k));
        logic [SQ_W-1:0] v_cur;
        logic [SQ_W:0]   r_cur;
        logic [SQ_W:0]   trial;
        logic [SQ_W-1:0] v_next;
        logic [SQ_W:0]   r_next;

        if (k == 0) begin : g_first
            assign v_cur = sq;
            assign r_cur = '0;
        end
        else begin : g_rest
            assign v_cur = v_reg[k-1];
            assign r_cur = r_reg[k-1];
        end

        always_comb
        begin
            trial = r_cur + BIT;
            if ({1'b0, v_cur} >= trial)
            begin
                v_next = v_cur - trial[SQ_W-1:0];
                r_next = (r_cur >> 1) + BIT;
            end
            else
            begin
                v_next = v_cur;
                r_next = r_cur >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k] <= v_next;
                r_reg[k] <= r_next;
            end
        end
    end

    assign root = r_reg[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

>>> rtl/crs_div.sv
// ============================================================================
// crs_div: pipelined restoring divider
// Unsigned quotient, one bit per register stage; the quotient is known
// to fit in Q_W bits.
// ============================================================================
module crs_div import crs_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [ROOT_W-1:0] den,
    output logic [Q_W-1:0]    quo
);

    logic [ROOT_W-1:0] rem_reg [DIV_STAGES];
    logic [ROOT_W-1:0] den_reg [DIV_STAGES];
    logic [Q_W-1:0]    lo_reg  [DIV_STAGES];
    logic [Q_W-1:0]    q_reg   [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_st
        logic [ROOT_W-1:0] rem_cur;
        logic [ROOT_W-1:0] den_cur;
        logic [Q_W-1:0]    lo_cur;
        logic [Q_W-1:0]    q_cur;
        logic [ROOT_W:0]   shifted;
        logic [ROOT_W-1:0] rem_next;
        logic              qbit;

        if (j == 0) begin : g_first
            assign rem_cur = ROOT_W'(num[NUM_W-1:Q_W]);
            assign den_cur = den;
            assign lo_cur  = num[Q_W-1:0];
            assign q_cur   = '0;
        end
        else begin : g_rest
            assign rem_cur = rem_reg[j-1];
            assign den_cur = den_reg[j-1];
            assign lo_cur  = lo_reg[j-1];
            assign q_cur   = q_reg[j-1];
        end

        always_comb
        begin
            shifted = {rem_cur, lo_cur[Q_W-1-j]};
            qbit    = shifted >= {1'b0, den_cur};
            if (qbit)
                rem_next = ROOT_W'(shifted - {1'b0, den_cur});
            else
                rem_next = shifted[ROOT_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                den_reg[j] <= den_cur;
                lo_reg[j]  <= lo_cur;
                q_reg[j]   <= {q_cur[Q_W-2:0], qbit};
            end
        end
    end

    assign quo = q_reg[DIV_STAGES-1];

endmodule

>>> rtl/catmull_rom_spline_evaluator.sv
// ============================================================================
// catmull_rom_spline_evaluator: uniform 3-D Catmull-Rom spline evaluator
// Control point store plus a fully pipelined position and unit gradient path.
// ============================================================================
// Usage:
// Items arrive on the cmd channel and each produces exactly one transfer on
// the rsp channel, in order. A load item writes one control point and answers
// with zeros; a position or gradient item evaluates segment param_t[21:16] at
// fraction param_t[15:0]. The looped and point_count registers are to be
// written through the cfg port only while no item is in flight; the block
// does not enforce this. Throughput is one item per cycle while results are
// taken. An item passes 12 blend and normalize stages, 31 square root
// stages (one root bit per stage) and 17 divider stages (one quotient bit
// per stage), then the output register. A load is visible to an evaluation
// accepted in the next cycle.
// When the receiver holds rsp.ready low with a result waiting, the whole
// pipeline freezes and cmd.ready drops; nothing is lost or repeated.
// Reset clears the pipeline valid bits and sets looped to 0 and point_count
// to 4. The point store is not cleared; points must be loaded before use.
// ============================================================================
module catmull_rom_spline_evaluator import crs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data,
    crs_cmd_if.sink           cmd,
    crs_rsp_if.source         rsp
);

    localparam int S8 = 7;
    localparam logic signed [SUM_W-1:0] RES_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] RES_MIN = ~RES_MAX;
    localparam logic signed [W_W-1:0]   W_ONE   = W_W'(1 << FRAC_BITS);

    logic             looped_reg;
    logic [CNT_W-1:0] point_count_reg;
    logic             adv;
    logic             cmd_acc;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            looped_reg      <= 1'b0;
            point_count_reg <= CNT_W'(CNT_MIN);
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                REG_LOOPED: looped_reg      <= cfg_data[0];
                REG_COUNT:  point_count_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: every stage moves together unless a result is held.
    // ------------------------------------------------------------------
    logic   rsp_valid_reg;
    assign adv       = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = adv;
    assign cmd_acc   = cmd.valid && adv;

    // ------------------------------------------------------------------
    // Decode: segment check and the four point indices
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] n_eff;
    logic [PT_AW-1:0] seg;
    logic [CNT_W-1:0] seg7;
    logic [CNT_W-1:0] s1;
    logic [CNT_W-1:0] s2;
    logic             oor;
    logic [PT_AW-1:0] idx [4];

    always_comb
    begin
        if (point_count_reg < CNT_W'(CNT_MIN))
            n_eff = CNT_W'(CNT_MIN);
        else if (point_count_reg > CNT_W'(MAX_POINTS))
            n_eff = CNT_W'(MAX_POINTS);
        else
            n_eff = point_count_reg;

        seg  = cmd.param_t[PARAM_W-1:FRAC_BITS];
        seg7 = {1'b0, seg};
        s1   = seg7 + CNT_W'(1);
        s2   = seg7 + CNT_W'(2);

        if (looped_reg)
        begin
            oor = seg7 >= n_eff;
            if (seg == '0)
                idx[0] = PT_AW'(n_eff - CNT_W'(1));
            else
                idx[0] = seg - PT_AW'(1);
            idx[1] = seg;
            idx[2] = (s1 == n_eff) ? '0 : s1[PT_AW-1:0];
            idx[3] = (s2 >= n_eff) ? PT_AW'(s2 - n_eff) : s2[PT_AW-1:0];
        end
        else
        begin
            oor    = (seg7 + CNT_W'(3)) >= n_eff;
            idx[0] = seg;
            idx[1] = s1[PT_AW-1:0];
            idx[2] = s2[PT_AW-1:0];
            idx[3] = seg + PT_AW'(3);
        end
    end

    // ------------------------------------------------------------------
    // Point store: two copies, each read at two addresses per cycle
    // ------------------------------------------------------------------
    coord_t mem_a [3][MAX_POINTS];
    coord_t mem_b [3][MAX_POINTS];
    coord_t cin   [3];

    assign cin[0] = cmd.coord_x;
    assign cin[1] = cmd.coord_y;
    assign cin[2] = cmd.coord_z;

    coord_t p1_reg [3][4];
    coord_t p2_reg [3][4];
    coord_t p3_reg [3][4];
    coord_t p4_reg [3][4];

    always_ff @(posedge clk)
    begin
        if (cmd_acc && (cmd.func == FUNC_LOAD))
        begin
            for (int k = 0; k < 3; k++)
            begin
                mem_a[k][cmd.point_index] <= cin[k];
                mem_b[k][cmd.point_index] <= cin[k];
            end
        end
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p1_reg[k][0] <= mem_a[k][idx[0]];
                p1_reg[k][1] <= mem_a[k][idx[1]];
                p1_reg[k][2] <= mem_b[k][idx[2]];
                p1_reg[k][3] <= mem_b[k][idx[3]];
            end
        end
    end

    // ------------------------------------------------------------------
    // Control pipeline
    // ------------------------------------------------------------------
    meta_t meta_reg [PIPE_DEPTH];
    meta_t meta1_next;
    meta_t meta8_next;

    always_comb
    begin
        meta1_next        = '0;
        meta1_next.valid  = cmd.valid;
        meta1_next.pos    = (cmd.func == FUNC_POS) && !oor;
        meta1_next.grad   = (cmd.func == FUNC_GRAD) && !oor;
        if (((cmd.func == FUNC_POS) || (cmd.func == FUNC_GRAD)) && oor)
            meta1_next.status = ST_RANGE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
                meta_reg[i] <= '0;
        end
        else if (adv)
        begin
            meta_reg[0] <= meta1_next;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                if (i == S8)
                    meta_reg[i] <= meta8_next;
                else
                    meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Basis weights and blend
    // ------------------------------------------------------------------
    logic [FRAC_BITS-1:0]   f1_reg;
    logic [FRAC_BITS-1:0]   f2_reg;
    logic [FRAC_BITS-1:0]   f3_reg;
    logic [UU_W-1:0]        uu2_reg;
    logic [UU_W-1:0]        uu3_reg;
    logic [UU_W-1:0]        uuu3_reg;
    logic [2*FRAC_BITS:0]   ff_next;
    logic [2*FRAC_BITS+1:0] fff_next;
    logic signed [W_W-1:0]  a_w;
    logic signed [W_W-1:0]  b_w;
    logic signed [W_W-1:0]  c_w;
    logic signed [W_W-1:0]  w_next [4];
    logic signed [W_W-1:0]  w4_reg [4];
    logic signed [PROD_W-1:0] prod5_reg [3][4];
    logic signed [SUM_W-1:0]  pair6_reg [3][2];
    logic signed [SUM_W-1:0]  sum7_reg  [3];

    always_comb
    begin
        ff_next  = (2*FRAC_BITS+1)'(f1_reg) * (2*FRAC_BITS+1)'(f1_reg)
                 + (2*FRAC_BITS+1)'(FRAC_HALF);
        fff_next = (2*FRAC_BITS+2)'(uu2_reg) * (2*FRAC_BITS+2)'(f2_reg)
                 + (2*FRAC_BITS+2)'(FRAC_HALF);

        a_w = W_W'(uuu3_reg);
        b_w = W_W'(uu3_reg);
        c_w = W_W'(f3_reg);
        if (meta_reg[2].pos)
        begin
            w_next[0] = -a_w + W_W'(2) * b_w - c_w;
            w_next[1] = W_W'(3) * a_w - W_W'(5) * b_w + W_W'(2) * W_ONE;
            w_next[2] = -(W_W'(3) * a_w) + W_W'(4) * b_w + c_w;
            w_next[3] = a_w - b_w;
        end
        else
        begin
            w_next[0] = -(W_W'(3) * b_w) + W_W'(4) * c_w - W_ONE;
            w_next[1] = W_W'(9) * b_w - W_W'(10) * c_w;
            w_next[2] = -(W_W'(9) * b_w) + W_W'(8) * c_w + W_ONE;
            w_next[3] = W_W'(3) * b_w - W_W'(2) * c_w;
        end
    end

    // ------------------------------------------------------------------
    // Position rounding, gradient magnitude and normalization
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] rnd   [3];
    logic signed [SUM_W-1:0] shv   [3];
    logic [SUM_W-1:0]        mag_next [3];
    logic [SUM_W-1:0]        m_next;
    logic [SUM_W-1:0]        mag8_reg [3];
    logic [SUM_W-1:0]        m8_reg;
    logic [MSB_W-1:0]        p_next;
    logic [MSB_W-1:0]        p9_reg;
    logic [SUM_W-1:0]        mag9_reg [3];
    logic [MSB_W-1:0]        sh_r;
    logic [MSB_W-1:0]        sh_l;
    logic [MAG_W-1:0]        mag10_next [3];
    logic [MAG_W-1:0]        mag10_reg [3];
    logic [MAG_W-1:0]        mag11_reg [3];
    logic [MAG_W-1:0]        mag12_reg [3];
    logic [2*MAG_W-1:0]      sq11_reg  [3];
    logic [SQ_W-1:0]         sq12_reg;

    always_comb
    begin
        meta8_next = meta_reg[S8-1];
        m_next     = '0;
        for (int k = 0; k < 3; k++)
        begin
            rnd[k] = sum7_reg[k] + SUM_W'(FRAC_HALF << 1);
            shv[k] = rnd[k] >>> (FRAC_BITS + 1);
            meta8_next.neg[k] = sum7_reg[k][SUM_W-1];
            mag_next[k] = sum7_reg[k][SUM_W-1] ? SUM_W'(-sum7_reg[k]) : SUM_W'(sum7_reg[k]);
            if (mag_next[k] > m_next)
                m_next = mag_next[k];
            if (meta_reg[S8-1].pos)
            begin
                if (shv[k] > RES_MAX)
                begin
                    meta8_next.res[k]  = COORD_W'(RES_MAX);
                    meta8_next.status  = ST_SAT;
                end
                else if (shv[k] < RES_MIN)
                begin
                    meta8_next.res[k]  = COORD_W'(RES_MIN);
                    meta8_next.status  = ST_SAT;
                end
                else
                    meta8_next.res[k]  = shv[k][COORD_W-1:0];
            end
        end
        if (meta_reg[S8-1].grad && (m_next == '0))
        begin
            meta8_next.zero   = 1'b1;
            meta8_next.status = ST_ZERO;
        end

        // Leading one of the largest magnitude.
        p_next = '0;
        for (int b = 0; b < SUM_W; b++)
        begin
            if (m8_reg[b])
                p_next = MSB_W'(b);
        end

        // Bring the largest magnitude into [2^29, 2^30).
        sh_r = p9_reg - MSB_W'(MAG_W - 1);
        sh_l = MSB_W'(MAG_W - 1) - p9_reg;
        for (int k = 0; k < 3; k++)
        begin
            if (p9_reg > MSB_W'(MAG_W - 1))
                mag10_next[k] = MAG_W'(mag9_reg[k] >> sh_r);
            else
                mag10_next[k] = MAG_W'(mag9_reg[k] << sh_l);
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers of the front stages
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg   <= cmd.param_t[FRAC_BITS-1:0];
            f2_reg   <= f1_reg;
            uu2_reg  <= ff_next[2*FRAC_BITS:FRAC_BITS];
            f3_reg   <= f2_reg;
            uu3_reg  <= uu2_reg;
            uuu3_reg <= fff_next[FRAC_BITS+UU_W-1:FRAC_BITS];
            p2_reg   <= p1_reg;
            p3_reg   <= p2_reg;
            p4_reg   <= p3_reg;
            w4_reg   <= w_next;
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 4; i++)
                    prod5_reg[k][i] <= PROD_W'(p4_reg[k][i]) * PROD_W'(w4_reg[i]);
                pair6_reg[k][0] <= SUM_W'(prod5_reg[k][0]) + SUM_W'(prod5_reg[k][1]);
                pair6_reg[k][1] <= SUM_W'(prod5_reg[k][2]) + SUM_W'(prod5_reg[k][3]);
                sum7_reg[k]     <= pair6_reg[k][0] + pair6_reg[k][1];
                mag8_reg[k]     <= mag_next[k];
                mag9_reg[k]     <= mag8_reg[k];
                mag10_reg[k]    <= mag10_next[k];
                mag11_reg[k]    <= mag10_reg[k];
                sq11_reg[k]     <= mag10_reg[k] * mag10_reg[k];
                mag12_reg[k]    <= mag11_reg[k];
            end
            m8_reg   <= m_next;
            p9_reg   <= p_next;
            sq12_reg <= SQ_W'(sq11_reg[0]) + SQ_W'(sq11_reg[1]) + SQ_W'(sq11_reg[2]);
        end
    end

    // ------------------------------------------------------------------
    // Length and unit scaling
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0] len;
    logic [MAG_W-1:0]  magd_reg [SQRT_STAGES][3];
    logic [NUM_W-1:0]  num [3];
    logic [Q_W-1:0]    quo [3];

    crs_isqrt u_isqrt (
        .clk  (clk),
        .en   (adv),
        .sq   (sq12_reg),
        .root (len)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            magd_reg[0] <= mag12_reg;
            for (int i = 1; i < SQRT_STAGES; i++)
                magd_reg[i] <= magd_reg[i-1];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_div
        assign num[k] = (NUM_W'(magd_reg[SQRT_STAGES-1][k]) << UNIT_SH)
                      + NUM_W'(len >> 1);

        crs_div u_div (
            .clk (clk),
            .en  (adv),
            .num (num[k]),
            .den (len),
            .quo (quo[k])
        );
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    meta_t               m_last;
    logic [COORD_W-1:0]  res_next [3];
    logic [COORD_W-1:0]  res_reg  [3];
    logic [1:0]          status_reg;

    always_comb
    begin
        m_last = meta_reg[PIPE_DEPTH-1];
        for (int k = 0; k < 3; k++)
        begin
            if (m_last.grad && !m_last.zero)
                res_next[k] = m_last.neg[k] ? -COORD_W'(quo[k]) : COORD_W'(quo[k]);
            else
                res_next[k] = m_last.res[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (adv)
            rsp_valid_reg <= m_last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg    <= res_next;
            status_reg <= m_last.status;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.res_x  = res_reg[0];
    assign rsp.res_y  = res_reg[1];
    assign rsp.res_z  = res_reg[2];
    assign rsp.status = status_reg;

endmodule

>>> rtl/crs_checker.sv
// ============================================================================
// crs_checker: port level checks of the Catmull-Rom spline evaluator
// Watches the stream ports and is bound to the top level.
// ============================================================================
module crs_checker import crs_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [COORD_W-1:0] res_x,
    input logic [COORD_W-1:0] res_y,
    input logic [COORD_W-1:0] res_z,
    input logic [1:0]         status
);

    // With no result waiting the block must take a new item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> cmd_ready)
        else $error("cmd not ready while no result is pending");

    // A held result blocks the input side.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !cmd_ready)
        else $error("cmd accepted while the result is stalled");

    // Range errors and zero gradients carry a zero vector.
    a_flag_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_RANGE || status == ST_ZERO)
            |-> res_x == '0 && res_y == '0 && res_z == '0)
        else $error("flagged result carries a nonzero vector");

    // A stalled result holds until its transfer.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_x) && $stable(res_y)
            && $stable(res_z) && $stable(status))
        else $error("stalled result changed");

endmodule

bind catmull_rom_spline_evaluator crs_checker u_crs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .res_x     (rsp.res_x),
    .res_y     (rsp.res_y),
    .res_z     (rsp.res_z),
    .status    (rsp.status)
);

>>> verif/tb_catmull_rom_spline_evaluator.sv
// ============================================================================
// tb_catmull_rom_spline_evaluator: self-checking testbench of the spline block
// Loads control points, then drives position and gradient evaluations under
// several register settings with random sender gaps and receiver stalls. Each
// response is compared against an in-house predictor of the spline math.
// ============================================================================
module tb_catmull_rom_spline_evaluator;
    import crs_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = PIPE_DEPTH + 10;
    localparam int WD_LIMIT    = 4000;

    typedef struct {
        func_e            func;
        logic [PT_AW-1:0] slot;
        coord_t           x;
        coord_t           y;
        coord_t           z;
        logic [PARAM_W-1:0] t;
    } cmd_item_t;

    typedef struct {
        coord_t     x;
        coord_t     y;
        coord_t     z;
        logic [1:0] status;
    } spline_res_t;

    logic clk;
    logic rst_n;
    logic cfg_en;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_data;

    crs_cmd_if cmd_if();
    crs_rsp_if rsp_if();

    catmull_rom_spline_evaluator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_en   (cfg_en),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cmd      (cmd_if),
        .rsp      (rsp_if)
    );

    // Predictor state: control points and register copies.
    coord_t     pt_x[MAX_POINTS];
    coord_t     pt_y[MAX_POINTS];
    coord_t     pt_z[MAX_POINTS];
    logic       mdl_looped;
    logic [6:0] mdl_count;

    // Generation-side view of the register settings.
    int gen_count_eff;
    logic gen_looped;

    cmd_item_t   cmd_pending[$];
    cmd_item_t   cmd_cur;
    spline_res_t expected_res[$];

    int  mismatches;
    bit  failed;
    bit  hold_req;
    bit  finishing;
    int  idle_cycles;
    bit  cmd_taken;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Applies one accepted command to the predictor and returns its response.
    task automatic spline_predict(input cmd_item_t c, output spline_res_t r);
        int n;
        int seg;
        int idx[4];
        longint f;
        longint uu;
        longint uuu;
        longint w[4];
        longint sum[3];
        longint rnd;
        longint unsigned mag[3];
        longint unsigned m;
        longint unsigned sq;
        longint unsigned len;
        longint unsigned q;
        bit neg[3];
        r = '{x: '0, y: '0, z: '0, status: ST_OK};
        if (c.func == FUNC_LOAD) begin
            pt_x[c.slot] = c.x;
            pt_y[c.slot] = c.y;
            pt_z[c.slot] = c.z;
            return;
        end
        if (c.func == FUNC_NONE)
            return;
        n = mdl_count;
        if (n < CNT_MIN) n = CNT_MIN;
        if (n > MAX_POINTS) n = MAX_POINTS;
        seg = c.t >> FRAC_BITS;
        f = c.t[FRAC_BITS-1:0];
        if (mdl_looped) begin
            if (seg >= n) begin
                r.status = ST_RANGE;
                return;
            end
            idx[0] = (seg == 0) ? n - 1 : seg - 1;
            idx[1] = seg;
            idx[2] = (seg + 1) % n;
            idx[3] = (seg + 2) % n;
        end
        else begin
            if (seg + 3 >= n) begin
                r.status = ST_RANGE;
                return;
            end
            for (int i = 0; i < 4; i++)
                idx[i] = seg + i;
        end
        uu  = (f * f + FRAC_HALF) >> FRAC_BITS;
        uuu = (uu * f + FRAC_HALF) >> FRAC_BITS;
        if (c.func == FUNC_POS) begin
            w[0] = -uuu + 2 * uu - f;
            w[1] = 3 * uuu - 5 * uu + 2 * (64'd1 << FRAC_BITS);
            w[2] = -3 * uuu + 4 * uu + f;
            w[3] = uuu - uu;
        end
        else begin
            w[0] = -3 * uu + 4 * f - (64'd1 << FRAC_BITS);
            w[1] = 9 * uu - 10 * f;
            w[2] = -9 * uu + 8 * f + (64'd1 << FRAC_BITS);
            w[3] = 3 * uu - 2 * f;
        end
        sum = '{0, 0, 0};
        for (int i = 0; i < 4; i++) begin
            sum[0] += longint'(pt_x[idx[i]]) * w[i];
            sum[1] += longint'(pt_y[idx[i]]) * w[i];
            sum[2] += longint'(pt_z[idx[i]]) * w[i];
        end
        if (c.func == FUNC_POS) begin
            for (int k = 0; k < 3; k++) begin
                rnd = (sum[k] + (64'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
                if (rnd > 64'sd2147483647) begin
                    rnd = 64'sd2147483647;
                    r.status = ST_SAT;
                end
                if (rnd < -64'sd2147483648) begin
                    rnd = -64'sd2147483648;
                    r.status = ST_SAT;
                end
                sum[k] = rnd;
            end
            r.x = sum[0][31:0];
            r.y = sum[1][31:0];
            r.z = sum[2][31:0];
            return;
        end
        m = 0;
        for (int k = 0; k < 3; k++) begin
            neg[k] = sum[k] < 0;
            mag[k] = neg[k] ? longint'(-sum[k]) : sum[k];
            if (mag[k] > m) m = mag[k];
        end
        if (m == 0) begin
            r.status = ST_ZERO;
            return;
        end
        // Bring the largest component into [2^29, 2^30) before the root.
        while (m >= (64'd1 << 30)) begin
            for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
            m = m >> 1;
        end
        while (m < (64'd1 << 29)) begin
            for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
            m = m << 1;
        end
        sq  = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = int_sqrt(sq);
        for (int k = 0; k < 3; k++) begin
            q = ((mag[k] << 16) + (len >> 1)) / len;
            sum[k] = neg[k] ? -longint'(q) : longint'(q);
        end
        r.x = sum[0][31:0];
        r.y = sum[1][31:0];
        r.z = sum[2][31:0];
    endtask

    // Remembers whether the offered command was taken at the last rising edge.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            cmd_taken <= 1'b0;
        else
            cmd_taken <= cmd_if.valid && cmd_if.ready;
    end

    // Driver: bursts of transfers separated by random gaps.
    int burst_left;
    int gap_left;
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cmd_if.valid       <= 1'b0;
            cmd_if.func        <= FUNC_LOAD;
            cmd_if.point_index <= '0;
            cmd_if.coord_x     <= '0;
            cmd_if.coord_y     <= '0;
            cmd_if.coord_z     <= '0;
            cmd_if.param_t     <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!cmd_if.valid || cmd_taken) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap_left > 0 || cmd_pending.size() == 0) begin
                if (gap_left > 0) gap_left--;
                cmd_if.valid <= 1'b0;
            end
            else begin
                cmd_cur = cmd_pending.pop_front();
                burst_left--;
                cmd_if.valid       <= 1'b1;
                cmd_if.func        <= cmd_cur.func;
                cmd_if.point_index <= cmd_cur.slot;
                cmd_if.coord_x     <= cmd_cur.x;
                cmd_if.coord_y     <= cmd_cur.y;
                cmd_if.coord_z     <= cmd_cur.z;
                cmd_if.param_t     <= cmd_cur.t;
            end
        end
    end

    // Receiver: stall pattern that changes mode, plus one long hold on request.
    int rx_mode;
    int rx_mode_left;
    int hold_left;
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            rx_mode_left = 0;
            hold_left    = 0;
        end
        else begin
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = $urandom_range(0, 2);
                    rx_mode_left = $urandom_range(10, 120);
                end
                rx_mode_left--;
                case (rx_mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= $urandom_range(0, 1);
                    default: rsp_if.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Monitor: predicts on every command transfer, checks every response transfer.
    spline_res_t pred;
    spline_res_t got;
    cmd_item_t   acc;
    always @(posedge clk) begin
        if (rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                acc.func = func_e'(cmd_if.func);
                acc.slot = cmd_if.point_index;
                acc.x    = cmd_if.coord_x;
                acc.y    = cmd_if.coord_y;
                acc.z    = cmd_if.coord_z;
                acc.t    = cmd_if.param_t;
                spline_predict(acc, pred);
                expected_res.push_back(pred);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got = '{x: rsp_if.res_x, y: rsp_if.res_y, z: rsp_if.res_z,
                        status: rsp_if.status};
                if (expected_res.size() == 0) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response x=%0d y=%0d z=%0d st=%0d",
                                 got.x, got.y, got.z, got.status);
                end
                else begin
                    pred = expected_res.pop_front();
                    if (got.x !== pred.x || got.y !== pred.y || got.z !== pred.z ||
                        got.status !== pred.status) begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp x=%0d y=%0d z=%0d st=%0d, got x=%0d y=%0d z=%0d st=%0d",
                                     pred.x, pred.y, pred.z, pred.status,
                                     got.x, got.y, got.z, got.status);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) || finishing)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return coord_t'($urandom_range(0, 1 << 21)) - (1 << 20);
            2: case ($urandom_range(0, 3))
                   0: return 32'h7FFF_FFFF;
                   1: return 32'h8000_0000;
                   2: return 32'h0000_0000;
                   default: return 32'hFFFF_FFFF;
               endcase
            default: return coord_t'($urandom_range(0, 255)) - 128;
        endcase
    endfunction

    task automatic push_load(input int slot, input coord_t x, input coord_t y, input coord_t z);
        cmd_item_t c;
        c = '{func: FUNC_LOAD, slot: slot, x: x, y: y, z: z, t: $urandom};
        cmd_pending.push_back(c);
    endtask

    task automatic push_eval(input func_e fn, input logic [PARAM_W-1:0] t);
        cmd_item_t c;
        c = '{func: fn, slot: $urandom, x: $urandom, y: $urandom, z: $urandom, t: t};
        cmd_pending.push_back(c);
    endtask

    task automatic push_random_item();
        int sel;
        int seg;
        logic [FRAC_BITS-1:0] frac;
        coord_t v;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            if ($urandom_range(0, 9) == 0) begin
                // One point with the same value in x, y and z.
                v = rand_coord();
                push_load($urandom_range(0, MAX_POINTS - 1), v, v, v);
            end
            else begin
                push_load($urandom_range(0, MAX_POINTS - 1), rand_coord(), rand_coord(),
                          rand_coord());
            end
        end
        else if (sel < 30) begin
            push_eval(FUNC_NONE, $urandom);
        end
        else begin
            if ($urandom_range(0, 9) == 0)
                seg = $urandom_range(0, MAX_POINTS - 1);
            else if (gen_looped)
                seg = $urandom_range(0, gen_count_eff - 1);
            else
                seg = $urandom_range(0, gen_count_eff - 4);
            case ($urandom_range(0, 5))
                0: frac = '0;
                1: frac = '1;
                default: frac = $urandom;
            endcase
            push_eval((sel < 65) ? FUNC_POS : FUNC_GRAD, {seg[PT_AW-1:0], frac});
        end
    endtask

    task automatic wait_drained();
        while (cmd_pending.size() != 0 || cmd_if.valid || expected_res.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        cfg_en   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(negedge clk);
        cfg_en <= 1'b0;
        @(negedge clk);
        if (addr == REG_LOOPED)
            mdl_looped = data[0];
        else
            mdl_count = data;
    endtask

    task automatic set_mode(input logic lp, input logic [6:0] cnt);
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        write_reg(REG_LOOPED, lp);
        write_reg(REG_COUNT, cnt);
        gen_looped    = lp;
        gen_count_eff = (cnt < CNT_MIN) ? CNT_MIN : (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
    endtask

    initial begin
        rst_n      = 1'b0;
        cfg_en     = 1'b0;
        cfg_addr   = '0;
        cfg_data   = '0;
        mismatches = 0;
        failed     = 1'b0;
        hold_req   = 1'b0;
        finishing  = 1'b0;
        idle_cycles = 0;
        mdl_looped = 1'b0;
        mdl_count  = 7'd4;
        gen_looped = 1'b0;
        gen_count_eff = 4;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Fill every slot so that no evaluation reads an unwritten entry.
        for (int i = 0; i < MAX_POINTS; i++)
            push_load(i, rand_coord(), rand_coord(), rand_coord());

        // Directed part at reset settings: open mode, four points.
        push_load(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        push_load(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        push_load(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        push_load(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        push_eval(FUNC_POS, 22'h00_8000);
        push_eval(FUNC_POS, 22'h00_4000);
        push_eval(FUNC_GRAD, 22'h00_0000);
        push_eval(FUNC_GRAD, 22'h00_FFFF);
        push_eval(FUNC_POS, 22'h01_0000);
        push_eval(FUNC_GRAD, 22'h3F_FFFF);
        push_eval(FUNC_NONE, 22'h3F_FFFF);
        for (int i = 0; i < 4; i++)
            push_load(i, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
        push_eval(FUNC_GRAD, 22'h00_1234);
        push_eval(FUNC_POS, 22'h00_FFFF);
        push_load(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_load(62, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_eval(FUNC_POS, 22'h00_0000);

        // Random phases over a range of register settings, extremes included.
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: set_mode(1'b1, 7'd4);
                1: set_mode(1'b0, 7'd64);
                2: set_mode(1'b1, 7'd64);
                3: set_mode(1'b0, 7'd0);
                4: set_mode(1'b1, 7'd127);
                5: set_mode(1'b0, 7'd127);
                6: set_mode(1'b1, 7'd1);
                default: set_mode($urandom_range(0, 1), $urandom_range(0, 127));
            endcase
            for (int i = 0; i < 100; i++)
                push_random_item();
            // Long receiver stall while commands keep coming, to back up the pipeline.
            if (ph == 2)
                hold_req = 1'b1;
        end

        wait_drained();
        finishing = 1'b1;
        repeat (SETTLE) @(negedge clk);
        if (!failed && expected_res.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
